// ----- src/contour_hull_proximity_filter_assert.svh -----
// Assertion macros shared by the checker.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef CONTOUR_HULL_PROXIMITY_FILTER_ASSERT_SVH
`define CONTOUR_HULL_PROXIMITY_FILTER_ASSERT_SVH

// Same-cycle implication.
`define CHPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/chpf_pkg.sv -----
`default_nettype none

package chpf_pkg;

    // Field widths fixed by the port definition
    localparam int PT_BITS  = 12;
    localparam int THR_BITS = 12;

    localparam logic [THR_BITS-1:0] THR_RESET = 12'd32;

    // Threshold carries four fractional bits
    localparam int FRAC_BITS = 4;

    // Scaled cross product at or above 2^A_LIMIT_BITS can never pass the test
    localparam int A_LIMIT_BITS = 29;

    // Point kind codes
    localparam logic KIND_HULL    = 1'b0;
    localparam logic KIND_CONTOUR = 1'b1;

    typedef logic [PT_BITS-1:0] pt_coord_t;

endpackage

`default_nettype wire

// ----- src/chpf_in_if.sv -----
`default_nettype none

interface chpf_in_if;
    import chpf_pkg::*;

    logic      valid;
    logic      ready;
    logic      kind;
    pt_coord_t point_x;
    pt_coord_t point_y;
    logic      start_new_hull;
    logic      last_contour_point;

    modport source (
        output valid, kind, point_x, point_y, start_new_hull, last_contour_point,
        input  ready
    );

    modport sink (
        input  valid, kind, point_x, point_y, start_new_hull, last_contour_point,
        output ready
    );

endinterface

`default_nettype wire

// ----- src/chpf_out_if.sv -----
`default_nettype none

interface chpf_out_if;
    import chpf_pkg::*;

    logic      valid;
    logic      ready;
    pt_coord_t out_x;
    pt_coord_t out_y;
    logic      near_hull;
    logic      object_end;
    logic      start_missing;

    modport source (
        output valid, out_x, out_y, near_hull, object_end, start_missing,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, near_hull, object_end, start_missing,
        output ready
    );

endinterface

`default_nettype wire

// ----- src/contour_hull_proximity_filter.sv -----
// Hull point: one transfer per cycle, no result.
// Contour point: no intake until the item is done; it passes DIFF, MUL, CMP and EMIT,
// plus ADV_WAIT when the hull edge advances; only EMIT once the start search failed.
// An object's first contour point adds SEARCH, and FIND_RD and FIND_WAIT on a hit;
// a stalled result holds the item in EMIT. One shared multiplier, seven products.
// rst_n (async, active low): control, count, cursor, edge cleared, threshold 32, store unset.
`default_nettype none

module contour_hull_proximity_filter #(
    parameter int HULL_DEPTH = 256,
    parameter int COORD_BITS = 12
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [chpf_pkg::THR_BITS-1:0] cfg_wr_data,
    chpf_in_if.sink                            points,
    chpf_out_if.source                         results
);
    import chpf_pkg::*;

    localparam int AW   = $clog2(HULL_DEPTH);
    localparam int CNTW = $clog2(HULL_DEPTH + 1);
    localparam int PW   = 2 * COORD_BITS;          // packed point, y above x
    localparam int DW   = COORD_BITS + 1;          // signed coordinate difference
    localparam int MW   = (2 * COORD_BITS + 2 > A_LIMIT_BITS + 1) ?
                          2 * COORD_BITS + 2 : A_LIMIT_BITS + 1;
    localparam int PRW  = 2 * MW;                  // full product
    localparam int AXW  = MW + FRAC_BITS;          // |cross| scaled by 16

    localparam int STEP_LAST = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FIND_RD,
        ST_FIND_WAIT,
        ST_DIFF,
        ST_MUL,
        ST_CMP,
        ST_EMIT,
        ST_ADV_WAIT
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // control (reset)
    state_t                 state_reg,      state_next;
    logic [THR_BITS-1:0]    thr_reg,        thr_next;
    logic [CNTW-1:0]        cnt_reg,        cnt_next;
    logic [AW-1:0]          cursor_reg,     cursor_next;
    logic [PW-1:0]          edge_start_reg, edge_start_next;
    logic [PW-1:0]          edge_end_reg,   edge_end_next;
    logic                   inside_reg,     inside_next;
    logic                   failed_reg,     failed_next;
    logic [CNTW-1:0]        scan_reg,       scan_next;
    logic                   cmp_vld_reg,    cmp_vld_next;
    logic [2:0]             step_reg,       step_next;
    logic                   out_vld_reg,    out_vld_next;
    pt_coord_t              out_x_reg,      out_x_next;
    pt_coord_t              out_y_reg,      out_y_next;
    logic                   out_near_reg,   out_near_next;
    logic                   out_end_reg,    out_end_next;
    logic                   out_miss_reg,   out_miss_next;

    // datapath (no reset)
    logic [PW-1:0]          pt_reg,         pt_next;
    logic                   last_reg,       last_next;
    logic [AW-1:0]          cmp_idx_reg,    cmp_idx_next;
    logic signed [DW-1:0]   ex_reg,         ex_next;
    logic signed [DW-1:0]   ey_reg,         ey_next;
    logic signed [DW-1:0]   px_reg,         px_next;
    logic signed [DW-1:0]   py_reg,         py_next;
    logic signed [PRW-1:0]  prod_reg,       prod_next;
    logic signed [MW-1:0]   len2_reg,       len2_next;
    logic signed [MW-1:0]   cross_reg,      cross_next;
    logic [PRW-1:0]         rhs_reg,        rhs_next;
    logic [A_LIMIT_BITS-1:0] a_reg,         a_next;
    logic                   a_big_reg,      a_big_next;
    logic                   near_reg,       near_next;

    // ------------------------------------------------------------------
    // Hull store
    // ------------------------------------------------------------------
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [PW-1:0]          mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [PW-1:0]          mem_rdata;

    chpf_ram #(
        .WIDTH (PW),
        .DEPTH (HULL_DEPTH)
    ) u_hull_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Step one hull point backwards, wrapping at the current count.
    function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i,
                                               input logic [CNTW-1:0] n);
        logic [CNTW-1:0] top;
        top = n - CNTW'(1);
        return (i == '0) ? top[AW-1:0] : i - AW'(1);
    endfunction

    // ------------------------------------------------------------------
    // Handshake and input unpacking
    // ------------------------------------------------------------------
    logic          in_xfer;
    logic          hull_xfer;
    logic          out_free;
    logic [PW-1:0] in_pt;
    logic          hit;
    logic          scan_done;
    logic [AW-1:0] cursor_prev;

    // Accept only between items; a full output register does not block intake.
    assign points.ready = (state_reg == ST_IDLE);
    assign in_xfer      = points.valid && points.ready;
    assign hull_xfer    = in_xfer && (points.kind == KIND_HULL);
    assign out_free     = !out_vld_reg || results.ready;

    assign in_pt = {COORD_BITS'(points.point_y), COORD_BITS'(points.point_x)};

    // Append a hull point (a new hull writes address 0); drop it once the store is full.
    assign mem_we    = hull_xfer &&
                       (points.start_new_hull || (cnt_reg < CNTW'(HULL_DEPTH)));
    assign mem_waddr = points.start_new_hull ? '0 : cnt_reg[AW-1:0];
    assign mem_wdata = in_pt;

    // Search compare works on the word read in the previous cycle.
    assign hit         = cmp_vld_reg && (mem_rdata == pt_reg);
    assign scan_done   = (scan_reg == cnt_reg);
    assign cursor_prev = prev_idx(cursor_reg, cnt_reg);

    always_comb
    begin
        case (state_reg)
            ST_SEARCH:  mem_raddr = scan_reg[AW-1:0];
            ST_EMIT:    mem_raddr = cursor_prev;
            default:    mem_raddr = cursor_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operand select by step
    // ------------------------------------------------------------------
    logic signed [MW-1:0]  mul_a;
    logic signed [MW-1:0]  mul_b;
    logic signed [PRW-1:0] mul_p;
    logic signed [MW-1:0]  prod_lo;
    logic [MW-1:0]         cross_mag;
    logic [AXW-1:0]        a_wide;

    always_comb
    begin
        case (step_reg)
            3'd0:
            begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(ex_reg);
            end
            3'd1:
            begin
                mul_a = MW'(ey_reg);
                mul_b = MW'(ey_reg);
            end
            3'd2:
            begin
                mul_a = MW'(ex_reg);
                mul_b = MW'(py_reg);
            end
            3'd3:
            begin
                mul_a = MW'(ey_reg);
                mul_b = MW'(px_reg);
            end
            3'd4:
            begin
                mul_a = signed'(MW'(thr_reg));
                mul_b = signed'(MW'(thr_reg));
            end
            3'd5:
            begin
                mul_a = prod_reg[MW-1:0];
                mul_b = len2_reg;
            end
            3'd6:
            begin
                mul_a = signed'(MW'(a_reg));
                mul_b = signed'(MW'(a_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign prod_lo   = prod_reg[MW-1:0];
    assign cross_mag = cross_reg[MW-1] ? unsigned'(-cross_reg) : unsigned'(cross_reg);
    assign a_wide    = {cross_mag, {FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        thr_next        = thr_reg;
        cnt_next        = cnt_reg;
        cursor_next     = cursor_reg;
        edge_start_next = edge_start_reg;
        edge_end_next   = edge_end_reg;
        inside_next     = inside_reg;
        failed_next     = failed_reg;
        scan_next       = scan_reg;
        cmp_vld_next    = cmp_vld_reg;
        step_next       = step_reg;
        out_vld_next    = out_vld_reg && !results.ready;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_near_next   = out_near_reg;
        out_end_next    = out_end_reg;
        out_miss_next   = out_miss_reg;

        pt_next         = pt_reg;
        last_next       = last_reg;
        cmp_idx_next    = cmp_idx_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        prod_next       = prod_reg;
        len2_next       = len2_reg;
        cross_next      = cross_reg;
        rhs_next        = rhs_reg;
        a_next          = a_reg;
        a_big_next      = a_big_reg;
        near_next       = near_reg;

        if (cfg_wr_en)
        begin
            thr_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (hull_xfer)
                begin
                    // A new hull restarts the count and ends any object in progress.
                    if (points.start_new_hull)
                    begin
                        cnt_next    = CNTW'(1);
                        inside_next = 1'b0;
                    end
                    else if (cnt_reg < CNTW'(HULL_DEPTH))
                    begin
                        cnt_next = cnt_reg + CNTW'(1);
                    end
                end
                else if (in_xfer)
                begin
                    pt_next   = in_pt;
                    last_next = points.last_contour_point;
                    near_next = 1'b0;
                    if (!inside_reg)
                    begin
                        // First point of an object: scan the hull for it.
                        inside_next  = 1'b1;
                        failed_next  = 1'b0;
                        scan_next    = '0;
                        cmp_vld_next = 1'b0;
                        state_next   = ST_SEARCH;
                    end
                    else if (failed_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (hit)
                begin
                    edge_start_next = pt_reg;
                    cursor_next     = prev_idx(cmp_idx_reg, cnt_reg);
                    state_next      = ST_FIND_RD;
                end
                else if (scan_done)
                begin
                    // No match (or empty hull): flag the whole object.
                    failed_next = 1'b1;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[AW-1:0];
                    scan_next    = scan_reg + CNTW'(1);
                end
            end

            ST_FIND_RD:
            begin
                state_next = ST_FIND_WAIT;
            end

            ST_FIND_WAIT:
            begin
                edge_end_next = mem_rdata;
                state_next    = ST_DIFF;
            end

            ST_DIFF:
            begin
                ex_next    = DW'(edge_end_reg[COORD_BITS-1:0])  -
                             DW'(edge_start_reg[COORD_BITS-1:0]);
                ey_next    = DW'(edge_end_reg[PW-1:COORD_BITS]) -
                             DW'(edge_start_reg[PW-1:COORD_BITS]);
                px_next    = DW'(pt_reg[COORD_BITS-1:0])        -
                             DW'(edge_start_reg[COORD_BITS-1:0]);
                py_next    = DW'(pt_reg[PW-1:COORD_BITS])       -
                             DW'(edge_start_reg[PW-1:COORD_BITS]);
                step_next  = '0;
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                // One product per step; fold the previous product in alongside.
                prod_next = mul_p;
                case (step_reg)
                    3'd1:    len2_next  = prod_lo;
                    3'd2:    len2_next  = len2_reg + prod_lo;
                    3'd3:    cross_next = prod_lo;
                    3'd4:    cross_next = cross_reg - prod_lo;
                    3'd5:
                    begin
                        a_next     = a_wide[A_LIMIT_BITS-1:0];
                        a_big_next = |a_wide[AXW-1:A_LIMIT_BITS];
                    end
                    3'd6:    rhs_next   = unsigned'(prod_reg);
                    default: ;
                endcase
                if (step_reg == 3'(STEP_LAST))
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end

            ST_CMP:
            begin
                // Zero-length edge keeps no point.
                near_next  = !a_big_reg && (len2_reg != '0) &&
                             (unsigned'(prod_reg) <= rhs_reg);
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_x_next    = PT_BITS'(pt_reg[COORD_BITS-1:0]);
                    out_y_next    = PT_BITS'(pt_reg[PW-1:COORD_BITS]);
                    out_near_next = near_reg && !failed_reg;
                    out_end_next  = last_reg;
                    out_miss_next = failed_reg;
                    if (last_reg)
                    begin
                        inside_next = 1'b0;
                    end
                    // Reaching the far end advances the edge one hull point backwards.
                    if (!failed_reg && (pt_reg == edge_end_reg))
                    begin
                        edge_start_next = edge_end_reg;
                        cursor_next     = cursor_prev;
                        state_next      = ST_ADV_WAIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_ADV_WAIT:
            begin
                edge_end_next = mem_rdata;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            cnt_reg        <= '0;
            cursor_reg     <= '0;
            edge_start_reg <= '0;
            edge_end_reg   <= '0;
            inside_reg     <= 1'b0;
            failed_reg     <= 1'b0;
            scan_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            step_reg       <= '0;
            out_vld_reg    <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_near_reg   <= 1'b0;
            out_end_reg    <= 1'b0;
            out_miss_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            cnt_reg        <= cnt_next;
            cursor_reg     <= cursor_next;
            edge_start_reg <= edge_start_next;
            edge_end_reg   <= edge_end_next;
            inside_reg     <= inside_next;
            failed_reg     <= failed_next;
            scan_reg       <= scan_next;
            cmp_vld_reg    <= cmp_vld_next;
            step_reg       <= step_next;
            out_vld_reg    <= out_vld_next;
            out_x_reg      <= out_x_next;
            out_y_reg      <= out_y_next;
            out_near_reg   <= out_near_next;
            out_end_reg    <= out_end_next;
            out_miss_reg   <= out_miss_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pt_reg      <= pt_next;
        last_reg    <= last_next;
        cmp_idx_reg <= cmp_idx_next;
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        prod_reg    <= prod_next;
        len2_reg    <= len2_next;
        cross_reg   <= cross_next;
        rhs_reg     <= rhs_next;
        a_reg       <= a_next;
        a_big_reg   <= a_big_next;
        near_reg    <= near_next;
    end

    assign results.valid         = out_vld_reg;
    assign results.out_x         = out_x_reg;
    assign results.out_y         = out_y_reg;
    assign results.near_hull     = out_near_reg;
    assign results.object_end    = out_end_reg;
    assign results.start_missing = out_miss_reg;

endmodule

`default_nettype wire

// ----- src/chpf_ram.sv -----
`default_nettype none

module chpf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/chpf_checker.sv -----
`default_nettype none

`include "contour_hull_proximity_filter_assert.svh"

module chpf_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               in_kind,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire chpf_pkg::pt_coord_t out_x,
    input wire chpf_pkg::pt_coord_t out_y,
    input wire logic               near_hull,
    input wire logic               start_missing
);
    import chpf_pkg::*;

    `CHPF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `CHPF_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_x) && $stable(out_y) && $stable(near_hull), "stalled result changed")
    `CHPF_ASSERT_IMP(a_miss_not_near, out_valid && start_missing, !near_hull, "near flagged on object with missing start")
    `CHPF_ASSERT_NXT(a_busy_after_contour, in_valid && in_ready && (in_kind == KIND_CONTOUR), !in_ready, "contour transfer did not hold off intake")

endmodule

bind contour_hull_proximity_filter chpf_checker u_chpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (points.valid),
    .in_ready      (points.ready),
    .in_kind       (points.kind),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_x         (results.out_x),
    .out_y         (results.out_y),
    .near_hull     (results.near_hull),
    .start_missing (results.start_missing)
);

`default_nettype wire

// ----- dv/contour_hull_proximity_filter_test.sv -----
module contour_hull_proximity_filter_test;
    import chpf_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int STORE_DEPTH   = 256;
    localparam int COORD_MAX     = (1 << PT_BITS) - 1;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int PHASES        = 8;
    // Quiet margin once every flag is back, covering hull points still in flight
    localparam int SETTLE_CYCLES = 24;
    localparam int LIMIT_TIME    = 16_000_000;

    // One transfer on the point channel
    typedef struct packed {
        logic      kind;
        pt_coord_t x;
        pt_coord_t y;
        logic      new_hull;
        logic      last;
    } point_rec_t;

    // One transfer on the result channel
    typedef struct packed {
        pt_coord_t x;
        pt_coord_t y;
        logic      near_hull;
        logic      obj_end;
        logic      missing;
    } flag_rec_t;

    typedef struct {
        int x;
        int y;
    } xy_t;

    // Tracks the hull walk of the block and holds the flags it still owes.
    class hull_flag_ledger;
        logic [2*PT_BITS-1:0] hull_pts [STORE_DEPTH];
        int unsigned          hull_len;
        int unsigned          cursor;
        logic [2*PT_BITS-1:0] edge_from;
        logic [2*PT_BITS-1:0] edge_to;
        bit                   in_object;
        bit                   start_lost;
        logic [THR_BITS-1:0]  threshold;
        flag_rec_t            awaited_flags[$];
        int                   mismatches;

        function new();
            hull_len   = 0;
            cursor     = 0;
            edge_from  = '0;
            edge_to    = '0;
            in_object  = 0;
            start_lost = 0;
            threshold  = THR_RESET;
            mismatches = 0;
        endfunction

        function int unsigned step_back(int unsigned i);
            return (i % hull_len + hull_len - 1) % hull_len;
        endfunction

        // Exact test: (16*|cross|)^2 <= thr^2 * len^2, zero-length edge never near
        function bit within_edge_band(logic [2*PT_BITS-1:0] p);
            longint ex, ey, px, py, len2, cr, a;
            ex = longint'(edge_to[PT_BITS-1:0]) - longint'(edge_from[PT_BITS-1:0]);
            ey = longint'(edge_to[2*PT_BITS-1:PT_BITS]) - longint'(edge_from[2*PT_BITS-1:PT_BITS]);
            px = longint'(p[PT_BITS-1:0]) - longint'(edge_from[PT_BITS-1:0]);
            py = longint'(p[2*PT_BITS-1:PT_BITS]) - longint'(edge_from[2*PT_BITS-1:PT_BITS]);
            len2 = ex * ex + ey * ey;
            if (len2 == 0)
                return 1'b0;
            cr = ex * py - ey * px;
            if (cr < 0)
                cr = -cr;
            a = cr << FRAC_BITS;
            if (a >= (longint'(1) << A_LIMIT_BITS))
                return 1'b0;
            return a * a <= longint'(threshold) * longint'(threshold) * len2;
        endfunction

        function void note_point(point_rec_t it);
            logic [2*PT_BITS-1:0] p;
            int unsigned          i;
            flag_rec_t            r;
            p = {it.y, it.x};
            if (it.kind == KIND_HULL)
            begin
                if (it.new_hull)
                begin
                    hull_len  = 0;
                    in_object = 0;
                end
                if (hull_len < STORE_DEPTH)
                begin
                    hull_pts[hull_len] = p;
                    hull_len++;
                end
                return;
            end
            // First point of an object: find the start of the walk
            if (!in_object)
            begin
                start_lost = 1;
                i = 0;
                while (i < hull_len && hull_pts[i] != p)
                    i++;
                if (i < hull_len)
                begin
                    edge_from  = hull_pts[i];
                    cursor     = step_back(i);
                    edge_to    = hull_pts[cursor];
                    start_lost = 0;
                end
                in_object = 1;
            end
            r.near_hull = 1'b0;
            if (!start_lost)
            begin
                r.near_hull = within_edge_band(p);
                if (p == edge_to)
                begin
                    edge_from = edge_to;
                    cursor    = step_back(cursor);
                    edge_to   = hull_pts[cursor];
                end
            end
            r.x       = it.x;
            r.y       = it.y;
            r.obj_end = it.last;
            r.missing = start_lost;
            awaited_flags.insert(awaited_flags.size(), r);
            if (it.last)
                in_object = 0;
        endfunction

        task report_mismatch(string what, int got, int want, flag_rec_t w);
            mismatches++;
            $display("%0t: %s: got %0d, expected %0d (point %0d,%0d)",
                     $time, what, got, want, w.x, w.y);
        endtask

        task check_flags(flag_rec_t got);
            flag_rec_t want;
            if (awaited_flags.size() == 0)
            begin
                report_mismatch("result with no point awaiting it", 1, 0, got);
                return;
            end
            want = awaited_flags.pop_front();
            if (got.x != want.x)
                report_mismatch("out_x", got.x, want.x, want);
            if (got.y != want.y)
                report_mismatch("out_y", got.y, want.y, want);
            if (got.near_hull !== want.near_hull)
                report_mismatch("near_hull", got.near_hull, want.near_hull, want);
            if (got.obj_end !== want.obj_end)
                report_mismatch("object_end", got.obj_end, want.obj_end, want);
            if (got.missing !== want.missing)
                report_mismatch("start_missing", got.missing, want.missing, want);
        endtask

        function int outstanding();
            return awaited_flags.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [THR_BITS-1:0] cfg_wr_data;

    chpf_in_if  points_ch();
    chpf_out_if results_ch();

    hull_flag_ledger ledger = new();

    // Current hull shape as the stimulus sees it; only the stored part is walked
    int  shape_x [512];
    int  shape_y [512];
    int  shape_len = 0;
    int  items_sent = 0;
    int  thr_now = 32;
    bit  send_steady = 0;
    bit  take_steady = 0;
    bit  allow_noise = 0;
    int  thr_plan [PHASES-1];

    contour_hull_proximity_filter #(
        .HULL_DEPTH(STORE_DEPTH),
        .COORD_BITS(PT_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .points     (points_ch),
        .results    (results_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    // Offer one point and hold it until the transfer. Valid stays high afterwards so
    // that a back-to-back point replaces it in the same step; callers that pause
    // drop valid themselves.
    task automatic send_point(logic k, int x, int y, logic nh, logic lst);
        point_rec_t it;
        int         gap;
        gap = send_steady ? 0 : $urandom_range(0, 8);
        // Randomize the field that this kind of point ignores
        if (k == KIND_HULL)
            lst = $urandom_range(0, 1);
        else
            nh = $urandom_range(0, 1);
        it.kind     = k;
        it.x        = pt_coord_t'(x);
        it.y        = pt_coord_t'(y);
        it.new_hull = nh;
        it.last     = lst;
        if (gap > 0)
        begin
            points_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        points_ch.valid              <= 1'b1;
        points_ch.kind               <= it.kind;
        points_ch.point_x            <= it.x;
        points_ch.point_y            <= it.y;
        points_ch.start_new_hull     <= it.new_hull;
        points_ch.last_contour_point <= it.last;
        do
            @(posedge clk);
        while (!points_ch.ready);
        ledger.note_point(it);
        items_sent++;
    endtask

    // Build a random hull: either across the whole field or inside a small box,
    // with an occasional repeated point (zero-length edge) and edge coordinates.
    task automatic gen_hull(int n);
        int bx, by, span, i;
        if ($urandom_range(0, 3) == 0)
        begin
            bx   = 0;
            by   = 0;
            span = COORD_MAX;
        end
        else
        begin
            span = $urandom_range(16, 600);
            bx   = $urandom_range(0, COORD_MAX - span);
            by   = $urandom_range(0, COORD_MAX - span);
        end
        for (i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 9) == 0)
            begin
                shape_x[i] = shape_x[i-1];
                shape_y[i] = shape_y[i-1];
            end
            else
            begin
                shape_x[i] = bx + $urandom_range(0, span);
                shape_y[i] = by + $urandom_range(0, span);
                if ($urandom_range(0, 11) == 0)
                    shape_x[i] = $urandom_range(0, 1) ? COORD_MAX : 0;
                if ($urandom_range(0, 11) == 0)
                    shape_y[i] = $urandom_range(0, 1) ? COORD_MAX : 0;
            end
        end
    endtask

    // Load the shape as a fresh hull; points past the store size are dropped by the block
    task automatic push_hull(int n);
        int i;
        for (i = 0; i < n; i++)
            send_point(KIND_HULL, shape_x[i], shape_y[i], i == 0, 1'b0);
        shape_len = (n < STORE_DEPTH) ? n : STORE_DEPTH;
    endtask

    // Walk the hull backwards from hull point s, dropping a few points near each
    // edge line before usually landing on its far end. s < 0 starts off the hull.
    task automatic trace_object(int s);
        xy_t  trail[$];
        xy_t  pt;
        int   cur, nxt, steps, m, j, t, d, k, lim, off;
        logic lst;
        if (s < 0)
        begin
            steps = $urandom_range(1, 5);
            repeat (steps)
            begin
                pt.x = $urandom_range(0, COORD_MAX);
                pt.y = $urandom_range(0, COORD_MAX);
                trail.insert(trail.size(), pt);
            end
        end
        else
        begin
            pt.x = shape_x[s];
            pt.y = shape_y[s];
            trail.insert(trail.size(), pt);
            cur   = s;
            lim   = (shape_len < 10) ? shape_len : 10;
            steps = $urandom_range(1, lim + 1);
            d     = thr_now / 16 + 2;
            repeat (steps)
            begin
                nxt = (cur + shape_len - 1) % shape_len;
                m   = $urandom_range(0, 3);
                for (j = 0; j < m; j++)
                begin
                    t    = $urandom_range(1, 15);
                    off  = $urandom_range(0, 2 * d);
                    pt.x = clamp_coord(shape_x[cur] + (shape_x[nxt] - shape_x[cur]) * t / 16
                                       + off - d);
                    off  = $urandom_range(0, 2 * d);
                    pt.y = clamp_coord(shape_y[cur] + (shape_y[nxt] - shape_y[cur]) * t / 16
                                       + off - d);
                    trail.insert(trail.size(), pt);
                end
                // Usually land on the far end so the edge advances
                if ($urandom_range(0, 9) != 0)
                begin
                    pt.x = shape_x[nxt];
                    pt.y = shape_y[nxt];
                    trail.insert(trail.size(), pt);
                end
                cur = nxt;
            end
        end
        for (k = 0; k < trail.size(); k++)
        begin
            // Sprinkle stray points: hull growth, hull reload, off-contour points
            if (allow_noise && $urandom_range(0, 29) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: send_point(KIND_HULL, $urandom_range(0, COORD_MAX),
                                  $urandom_range(0, COORD_MAX), 1'b0, 1'b0);
                    1: send_point(KIND_HULL, $urandom_range(0, COORD_MAX),
                                  $urandom_range(0, COORD_MAX), 1'b1, 1'b0);
                    default: send_point(KIND_CONTOUR, $urandom_range(0, COORD_MAX),
                                        $urandom_range(0, COORD_MAX), 1'b0, 1'b0);
                endcase
            end
            // Leave an object open now and then so the next one continues it
            lst = (k == trail.size() - 1) && ($urandom_range(0, 19) != 0);
            send_point(KIND_CONTOUR, trail[k].x, trail[k].y, 1'b0, lst);
        end
    endtask

    // Hold the sender until every flag is back and the block has gone quiet,
    // then write the threshold.
    task automatic settle_and_write(int v);
        points_ch.valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[THR_BITS-1:0];
        @(posedge clk);
        cfg_wr_en        <= 1'b0;
        ledger.threshold = v[THR_BITS-1:0];
        thr_now          = v;
    endtask

    // Result side: stall a random number of cycles before each transfer,
    // with stretches of no stalling at all.
    initial
    begin
        int        gap;
        int        taken;
        flag_rec_t got;
        taken = 0;
        results_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = take_steady ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!results_ch.valid);
            got.x         = results_ch.out_x;
            got.y         = results_ch.out_y;
            got.near_hull = results_ch.near_hull;
            got.obj_end   = results_ch.object_end;
            got.missing   = results_ch.start_missing;
            ledger.check_flags(got);
            taken++;
            if (taken % 50 == 0)
                take_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // Stimulus
    initial
    begin
        int p, target, r, n;
        rst_n                        <= 1'b0;
        cfg_wr_en                    <= 1'b0;
        cfg_wr_data                  <= '0;
        points_ch.valid              <= 1'b0;
        points_ch.kind               <= KIND_HULL;
        points_ch.point_x            <= '0;
        points_ch.point_y            <= '0;
        points_ch.start_new_hull     <= 1'b0;
        points_ch.last_contour_point <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Contour point before any hull: empty hull, start missing
        send_point(KIND_CONTOUR, 0, 0, 1'b0, 1'b1);

        // Triangle on the field corners, walked all the way round
        shape_x[0] = 0;         shape_y[0] = 0;
        shape_x[1] = COORD_MAX; shape_y[1] = 0;
        shape_x[2] = COORD_MAX; shape_y[2] = COORD_MAX;
        push_hull(3);
        send_point(KIND_CONTOUR, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, COORD_MAX, 2000, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, COORD_MAX - 1, 2000, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 4000, 2000, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, COORD_MAX, 0, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 2000, 0, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 0, 0, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 2048, 2047, 1'b0, 1'b1);

        // Object whose first point is not on the hull
        send_point(KIND_CONTOUR, 1, 2, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, COORD_MAX, 0, 1'b0, 1'b1);

        // Repeated hull point: the walk crosses a zero-length edge
        shape_x[0] = 5;   shape_y[0] = 5;
        shape_x[1] = 100; shape_y[1] = 100;
        shape_x[2] = 100; shape_y[2] = 100;
        push_hull(3);
        send_point(KIND_CONTOUR, 100, 100, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 50, 50, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 5, 5, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 50, 51, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 100, 100, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 100, 100, 1'b0, 1'b0);
        send_point(KIND_CONTOUR, 50, 50, 1'b0, 1'b1);

        // Overfill the hull store, then walk from deep inside it
        send_steady = 1;
        gen_hull(STORE_DEPTH + 2);
        push_hull(STORE_DEPTH + 2);
        send_steady = 0;
        trace_object(200);

        // Threshold settings for the later phases, extremes first
        thr_plan[0] = 0;
        thr_plan[1] = COORD_MAX;
        thr_plan[2] = 16;
        thr_plan[3] = $urandom_range(1, COORD_MAX - 1);
        thr_plan[4] = 1;
        thr_plan[5] = $urandom_range(1, COORD_MAX - 1);
        thr_plan[6] = 160;

        // Random objects, mostly well-formed walks over small hulls
        allow_noise = 1;
        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
                settle_and_write(thr_plan[p-1]);
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
            begin
                send_steady = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 4) != 0 || shape_len == 0)
                begin
                    r = $urandom_range(0, 29);
                    if (r == 0)
                        n = $urandom_range(100, STORE_DEPTH + 4);
                    else if (r == 1)
                        n = $urandom_range(1, 2);
                    else
                        n = $urandom_range(3, 12);
                    gen_hull(n);
                    push_hull(n);
                end
                if ($urandom_range(0, 6) == 0)
                    trace_object(-1);
                else
                    trace_object($urandom_range(0, shape_len - 1));
            end
        end

        // Drain: drop valid, wait for every flag, then let the block go quiet
        points_ch.valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("contour_hull_proximity_filter: match");
        else
            $display("contour_hull_proximity_filter: mismatch");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #(LIMIT_TIME);
        $display("contour_hull_proximity_filter: mismatch");
        $finish;
    end

endmodule

// ----- contour_hull_proximity_filter.f -----
+incdir+src
src/chpf_pkg.sv
src/chpf_in_if.sv
src/chpf_out_if.sv
src/chpf_ram.sv
src/contour_hull_proximity_filter.sv
src/chpf_checker.sv
dv/contour_hull_proximity_filter_test.sv
